// File: hdl/assert_macros.svh
// Shared assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define ASSERT_CLK(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked implication, disabled while reset is asserted (active low).
`define ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hdl/srs_pkg.sv
package srs_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_PATTERN_BYTES      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       line_end;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_line_end;
        logic       last_of_run;
    } out_t;

    typedef struct packed {
        logic [63:0] pattern_bytes;
        logic [3:0]  pattern_length;
        logic [63:0] replacement_bytes;
        logic [3:0]  replacement_length;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic emit_head;
        logic emit_rep;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic match;
        logic eol;
        logic one_held;
        logic rep_last;
        logic out_free;
    } sts_t;

endpackage

// File: hdl/srs_cfg.sv
module srs_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [srs_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [srs_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [srs_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output srs_pkg::cfg_t                  cfg
);
    import srs_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_PATTERN_BYTES:      cfg_next.pattern_bytes      = pwdata;
                REG_PATTERN_LENGTH:     cfg_next.pattern_length     = pwdata[3:0];
                REG_REPLACEMENT_BYTES:  cfg_next.replacement_bytes  = pwdata;
                REG_REPLACEMENT_LENGTH: cfg_next.replacement_length = pwdata[3:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PATTERN_BYTES:      prdata = cfg_reg.pattern_bytes;
            REG_PATTERN_LENGTH:     prdata = {60'd0, cfg_reg.pattern_length};
            REG_REPLACEMENT_BYTES:  prdata = cfg_reg.replacement_bytes;
            REG_REPLACEMENT_LENGTH: prdata = {60'd0, cfg_reg.replacement_length};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_bytes      <= '0;
            cfg_reg.pattern_length     <= 4'd1;
            cfg_reg.replacement_bytes  <= '0;
            cfg_reg.replacement_length <= 4'd1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hdl/srs_ctrl.sv
module srs_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  srs_pkg::sts_t sts,
    output srs_pkg::cmd_t cmd
);
    import srs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_REPL  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.full && sts.match) begin
                    state_next = ST_REPL;
                end else if (sts.full) begin
                    // hold until the output slot frees up
                    if (sts.out_free) begin
                        cmd.emit_head = 1'b1;
                        state_next    = (sts.eol && !sts.one_held) ? ST_FLUSH : ST_IDLE;
                    end
                end else begin
                    state_next = sts.eol ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_REPL: begin
                if (sts.out_free) begin
                    cmd.emit_rep = 1'b1;
                    if (sts.rep_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (sts.out_free) begin
                    cmd.emit_head = 1'b1;
                    if (sts.one_held) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/srs_dp.sv
`include "assert_macros.svh"

module srs_dp #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  srs_pkg::cfg_t cfg,
    input  srs_pkg::cmd_t cmd,
    output srs_pkg::sts_t sts,
    input  srs_pkg::in_t  s_item,
    output logic          m_valid,
    input  logic          m_ready,
    output srs_pkg::out_t m_item
);
    import srs_pkg::*;

    localparam int HC_W  = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int RI_W  = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1;

    function automatic logic [3:0] clamp_len(input logic [3:0] len, input logic [3:0] maxv);
        logic [3:0] res;
        if (len == 4'd0) begin
            res = 4'd1;
        end else if (len > maxv) begin
            res = maxv;
        end else begin
            res = len;
        end
        return res;
    endfunction

    logic [7:0]      window_reg [MAX_PATTERN];
    logic [HC_W-1:0] held_reg;
    logic [HC_W-1:0] held_next;
    logic [HC_W-1:0] act_len_reg;
    logic [HC_W-1:0] act_len_next;
    logic            eol_reg;
    logic [RI_W-1:0] rep_idx_reg;
    logic [RI_W-1:0] rep_idx_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    out_t            out_reg;
    out_t            out_next;

    logic            out_free;
    logic            match;
    logic            one_held;
    logic            rep_last;
    logic [3:0]      rlen_m1;
    logic [7:0]      rep_word;

    assign out_free = !out_valid_reg || m_ready;
    assign one_held = (held_reg == HC_W'(1));
    assign rlen_m1  = clamp_len(cfg.replacement_length, 4'(MAX_REPLACEMENT)) - 4'd1;
    assign rep_last = (4'(rep_idx_reg) == rlen_m1);
    assign rep_word = cfg.replacement_bytes[{rep_idx_reg, 3'b000} +: 8];

    always_comb begin
        match = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((HC_W'(i) < act_len_reg) && (window_reg[i] != cfg.pattern_bytes[8*i +: 8])) begin
                match = 1'b0;
            end
        end
    end

    always_comb begin
        sts.full     = (held_reg == act_len_reg);
        sts.match    = match;
        sts.eol      = eol_reg;
        sts.one_held = one_held;
        sts.rep_last = rep_last;
        sts.out_free = out_free;
    end

    always_comb begin
        held_next    = held_reg;
        act_len_next = act_len_reg;
        rep_idx_next = rep_idx_reg;
        if (cmd.accept) begin
            held_next    = held_reg + HC_W'(1);
            rep_idx_next = '0;
            if (held_reg == '0) begin
                act_len_next = HC_W'(clamp_len(cfg.pattern_length, 4'(MAX_PATTERN)));
            end
        end else if (cmd.emit_head) begin
            held_next = held_reg - HC_W'(1);
        end else if (cmd.emit_rep) begin
            rep_idx_next = rep_idx_reg + RI_W'(1);
            if (rep_last) begin
                held_next = '0;
            end
        end
    end

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (cmd.emit_head) begin
            out_valid_next        = 1'b1;
            out_next.out_byte     = window_reg[0];
            out_next.out_line_end = eol_reg && one_held;
            out_next.last_of_run  = !eol_reg || one_held;
        end else if (cmd.emit_rep) begin
            out_valid_next        = 1'b1;
            out_next.out_byte     = rep_word[7:0];
            out_next.out_line_end = eol_reg && rep_last;
            out_next.last_of_run  = rep_last;
        end
    end

    // Window: write at the fill position, drop the oldest byte on each head emit.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (cmd.accept) begin
                if (held_reg[IDX_W-1:0] == IDX_W'(i)) begin
                    window_reg[i] <= s_item.text_byte;
                end
            end else if (cmd.emit_head) begin
                window_reg[i] <= (i < MAX_PATTERN - 1) ? window_reg[(i + 1) % MAX_PATTERN]
                                                       : 8'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            eol_reg <= s_item.line_end;
        end
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg      <= '0;
            act_len_reg   <= HC_W'(1);
            rep_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            held_reg      <= held_next;
            act_len_reg   <= act_len_next;
            rep_idx_reg   <= rep_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    `ASSERT_CLK(a_held_bound, aclk, aresetn, held_reg <= act_len_reg, "window overfilled")
    `ASSERT_CLK(a_len_range, aclk, aresetn,
        (act_len_reg != '0) && (act_len_reg <= HC_W'(MAX_PATTERN)), "active length out of range")
    `ASSERT_IMP(a_emit_free, aclk, aresetn, cmd.emit_head || cmd.emit_rep, out_free,
        "emit into occupied output slot")
    `ASSERT_IMP(a_head_nonempty, aclk, aresetn, cmd.emit_head, held_reg != '0,
        "head emit from empty window")

endmodule

// File: hdl/substring_replace_stream.sv
// Streaming replace-all: bytes of a line enter one request at a time and are held in a window
// as long as the pattern; a full window that equals the pattern is replaced by the replacement
// bytes, otherwise its oldest byte goes out, and a line-end byte flushes what is left. An
// input byte is taken only while the controller is idle, and each byte is accepted, then
// compared, before the next one is taken; a match then sends the replacement bytes one by one
// and a line end the flushed bytes, each emitted through the single output register, so the
// output side's stalls add directly. Config registers sit at byte addresses 0, 8, 16 and 24
// and should be written only while no line is in flight; a new pattern length takes effect
// once the window is empty.
module substring_replace_stream #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  srs_pkg::in_t                   s_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output srs_pkg::out_t                  m_item,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [srs_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [srs_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [srs_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import srs_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    srs_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    srs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    srs_dp #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .cmd     (cmd),
        .sts     (sts),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

// File: test/tb_substring_replace_stream.sv
`timescale 1ns / 100ps

module tb_substring_replace_stream;
    import srs_pkg::*;

    localparam int MAX_PAT_LEN     = 8;
    localparam int MAX_REP_LEN     = 8;
    localparam int RANDOM_ITEMS    = 500;
    localparam int SETTLE_CYCLES   = 20;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;

    class replace_scoreboard;
        logic [63:0] pattern;
        logic [3:0]  pattern_len_reg;
        logic [63:0] replacement;
        logic [3:0]  replacement_len_reg;
        logic [7:0]  window [8];
        int unsigned held;
        int unsigned active_len;
        out_t        run_q [$];
        out_t        expected_out_q [$];
        int          errors;

        function new();
            pattern             = '0;
            pattern_len_reg     = 4'd1;
            replacement         = '0;
            replacement_len_reg = 4'd1;
            foreach (window[i]) window[i] = 8'h00;
            held       = 0;
            active_len = 1;
            errors     = 0;
        endfunction

        function int unsigned clamp_length(logic [3:0] v, int unsigned max_len);
            if (v == 4'd0) return 1;
            if (32'(v) > max_len) return max_len;
            return 32'(v);
        endfunction

        function void set_register(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
            case (idx)
                REG_PATTERN_BYTES:      pattern = value;
                REG_PATTERN_LENGTH:     pattern_len_reg = value[3:0];
                REG_REPLACEMENT_BYTES:  replacement = value;
                REG_REPLACEMENT_LENGTH: replacement_len_reg = value[3:0];
                default: ;
            endcase
        endfunction

        function void emit_byte(logic [7:0] b, logic eol);
            out_t r;
            r.out_byte     = b;
            r.out_line_end = eol;
            r.last_of_run  = 1'b0;
            run_q.push_back(r);
        endfunction

        function void drop_head();
            for (int i = 1; i < 8; i++) window[i-1] = window[i];
            window[7] = 8'h00;
            held--;
        endfunction

        // Rewrite one accepted byte into the bytes it releases.
        function void note_request(in_t req);
            bit          hit;
            int unsigned rlen;
            run_q.delete();
            if (held == 0) active_len = clamp_length(pattern_len_reg, MAX_PAT_LEN);
            window[held] = req.text_byte;
            held++;
            if (held == active_len) begin
                hit = 1'b1;
                for (int i = 0; i < active_len; i++)
                    if (window[i] != pattern[8*i +: 8]) hit = 1'b0;
                if (hit) begin
                    rlen = clamp_length(replacement_len_reg, MAX_REP_LEN);
                    for (int i = 0; i < rlen; i++)
                        emit_byte(replacement[8*i +: 8], req.line_end && (i == rlen - 1));
                    foreach (window[i]) window[i] = 8'h00;
                    held = 0;
                end else begin
                    emit_byte(window[0], req.line_end && (held == 1));
                    drop_head();
                end
            end
            if (req.line_end) begin
                while (held > 0) begin
                    emit_byte(window[0], held == 1);
                    drop_head();
                end
            end
            if (run_q.size() > 0) run_q[run_q.size()-1].last_of_run = 1'b1;
            foreach (run_q[i]) expected_out_q.push_back(run_q[i]);
        endfunction

        function void check_result(out_t got);
            out_t exp_out;
            if (expected_out_q.size() == 0) begin
                $display("%0t: unexpected result byte %02h line_end %0b last %0b",
                         $time, got.out_byte, got.out_line_end, got.last_of_run);
                errors++;
                return;
            end
            exp_out = expected_out_q.pop_front();
            if (got !== exp_out) begin
                $display("%0t: mismatch: expected %02h eol %0b last %0b, got %02h eol %0b last %0b",
                         $time, exp_out.out_byte, exp_out.out_line_end, exp_out.last_of_run,
                         got.out_byte, got.out_line_end, got.last_of_run);
                errors++;
            end
        endfunction

        function int pending();
            return expected_out_q.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_t                   s_item;
    logic                  m_valid;
    logic                  m_ready;
    out_t                  m_item;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    replace_scoreboard sb = new();

    int unsigned req_count    = 0;
    int unsigned res_count    = 0;
    int unsigned quiet_cycles = 0;
    int unsigned rand_items   = 0;
    bit          sender_burst   = 1'b0;
    bit          receiver_burst = 1'b0;
    bit          hold_off_req   = 1'b0;
    logic [63:0] cur_pattern;
    int unsigned cur_plen;

    substring_replace_stream u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Monitor and watchdog: sample both channels at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_request(s_item);
                req_count++;
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_item);
                res_count++;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("** substring_replace_stream: FAILED **");
                    $finish;
                end
            end
        end
    end

    // Result sink: random stalls, plus one long hold-off on request.
    initial begin : result_sink
        int unsigned gap;
        int unsigned seen;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = receiver_burst ? 0 : $urandom_range(0, 14);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                gap = HOLD_OFF_CYCLES;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            seen = res_count;
            do @(negedge aclk); while (res_count == seen);
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic eol);
        int unsigned gap;
        int unsigned seen;
        in_t         req;
        gap = sender_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        req.text_byte = ch;
        req.line_end  = eol;
        s_valid <= 1'b1;
        s_item  <= req;
        seen = req_count;
        do @(negedge aclk); while (req_count == seen);
    endtask

    // Stop offering, let every expected byte drain, then let the block settle.
    task automatic wait_for_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(negedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_register(idx, value);
    endtask

    task automatic configure(input logic [63:0] pat, input logic [3:0] plen,
                             input logic [63:0] rep, input logic [3:0] rlen);
        write_register(REG_PATTERN_BYTES, pat);
        write_register(REG_PATTERN_LENGTH, {60'd0, plen});
        write_register(REG_REPLACEMENT_BYTES, rep);
        write_register(REG_REPLACEMENT_LENGTH, {60'd0, rlen});
        cur_pattern = pat;
        cur_plen    = sb.clamp_length(plen, MAX_PAT_LEN);
    endtask

    function automatic logic [3:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 4'd0;
            1:       return 4'($urandom_range(9, 15));
            2:       return 4'd8;
            3:       return 4'd1;
            default: return 4'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic configure_random();
        logic [63:0] pat;
        for (int i = 0; i < 8; i++)
            pat[8*i +: 8] = ($urandom_range(0, 3) != 0) ? 8'(8'h61 + $urandom_range(0, 3))
                                                        : 8'($urandom_range(0, 255));
        configure(pat, pick_length(), {$urandom, $urandom}, pick_length());
    endtask

    // Build a line mostly out of pattern copies and near misses.
    task automatic send_line();
        logic [7:0]  line_q [$];
        int unsigned target;
        int unsigned kind;
        int unsigned cut;
        bit          noise;
        target = $urandom_range(1, 20);
        noise  = ($urandom_range(0, 7) == 0);
        while (line_q.size() < target) begin
            kind = noise ? 9 : $urandom_range(0, 9);
            if (kind <= 4) begin
                for (int i = 0; i < cur_plen; i++) line_q.push_back(cur_pattern[8*i +: 8]);
            end else if (kind <= 6) begin
                cut = (cur_plen > 1) ? $urandom_range(1, cur_plen - 1) : 1;
                for (int i = 0; i < cut; i++) line_q.push_back(cur_pattern[8*i +: 8]);
            end else if (kind <= 8) begin
                line_q.push_back(8'(8'h61 + $urandom_range(0, 3)));
            end else begin
                line_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        // Sometimes reconfigure partway through, with the window possibly holding bytes.
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, line_q.size() - 1) : line_q.size();
        sender_burst   = ($urandom_range(0, 3) == 0);
        receiver_burst = ($urandom_range(0, 3) == 0);
        foreach (line_q[i]) begin
            if (i == cut) begin
                wait_for_idle();
                configure_random();
            end
            send_char(line_q[i], i == line_q.size() - 1);
            rand_items++;
        end
    endtask

    initial begin : stimulus
        int unsigned phase;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;
        m_ready = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        cur_pattern = '0;
        cur_plen    = 1;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: single zero byte replaced by zero.
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);

        // "ab" -> "XYZ": miss then match, lone flush, match between flushed bytes.
        wait_for_idle();
        configure(64'h6261, 4'd2, 64'h5A5958, 4'd3);
        send_char("a", 1'b0);
        send_char("a", 1'b0);
        send_char("b", 1'b1);
        send_char("a", 1'b1);
        send_char("b", 1'b0);
        send_char("a", 1'b0);
        send_char("b", 1'b0);
        send_char("a", 1'b1);

        // Pattern length changed with one byte held: old length stays until the window empties.
        send_char("a", 1'b0);
        wait_for_idle();
        write_register(REG_PATTERN_BYTES, 64'h636261);
        write_register(REG_PATTERN_LENGTH, 64'd3);
        send_char("b", 1'b0);
        send_char("c", 1'b0);
        send_char("x", 1'b1);

        // Zero pattern length acts as one, oversized replacement length saturates.
        wait_for_idle();
        configure(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 64'h0123_4567_89AB_CDEF, 4'd15);
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b1);

        // Oversized pattern length saturates to eight, zero replacement length acts as one.
        wait_for_idle();
        configure(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 64'h0, 4'd0);
        for (int i = 0; i < 8; i++) send_char(8'hFF, i == 7);

        phase = 0;
        while (rand_items < RANDOM_ITEMS) begin
            wait_for_idle();
            configure_random();
            if (phase % 6 == 0) hold_off_req = 1'b1;
            repeat ($urandom_range(3, 6)) send_line();
            phase++;
        end

        wait_for_idle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** substring_replace_stream: PASSED **");
        end else begin
            $display("** substring_replace_stream: FAILED **");
        end
        $finish;
    end

endmodule
